// ===== src/htfd_pkg.sv =====
// constants and crc helper for the humidity and temperature frame decoder
`timescale 1ns / 1ps

package htfd_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int CNT_W       = 3;

  localparam logic [CNT_W-1:0] FIRST_POS = CNT_W'(0);
  localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // fixed-point scale factors, applied as raw * scale >> 20
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  // one byte of crc-8, msb first, no final xor
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/humid_temp_frame_decoder.sv =====
// humidity and temperature sensor reply decoder, top level
// a reply's seventh byte passes through the input register and then the result register before it shows on the output
// throughput: one byte per cycle unless a held result stalls; the input register and result register each hold one item
// bytes before the seventh produce no output transaction
// reset: synchronous active-low rst_n clears byte count and both valid flags
`timescale 1ns / 1ps

module humid_temp_frame_decoder
  import htfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // sensor_status, humidity_raw, temperature_raw, humidity_centi, temperature_centi, pad
  output logic [79:0] out_tdata,
  output logic        out_tuser   // check_status
);

  logic             in_valid_r;
  logic [7:0]       byte_r;
  logic             start_r;

  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       crc_r;
  logic [39:0]      payload_r;
  logic [7:0]       status_r;

  logic             out_valid_r;
  logic [7:0]       o_status_r;
  logic [19:0]      o_hum_raw_r;
  logic [19:0]      o_temp_raw_r;
  logic [13:0]      o_hum_centi_r;
  logic [14:0]      o_temp_centi_r;
  logic             o_check_r;

  logic             out_free;
  logic             advance;
  logic [CNT_W-1:0] pos;
  logic             last_byte;
  logic [13:0]      hum_centi;
  logic signed [14:0] temp_centi;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_comb begin
    if (start_r || cnt_r > LAST_POS) begin
      pos = FIRST_POS;
    end else begin
      pos = cnt_r;
    end
  end

  assign last_byte = (pos == LAST_POS);

  htfd_convert u_convert (
    .humidity_raw      (payload_r[39:20]),
    .temperature_raw   (payload_r[19:0]),
    .humidity_centi    (hum_centi),
    .temperature_centi (temp_centi)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= FIRST_POS;
      crc_r     <= CRC_INIT;
      payload_r <= 40'b0;
      status_r  <= 8'b0;
    end else if (advance) begin
      if (pos == FIRST_POS) begin
        status_r  <= byte_r;
        crc_r     <= crc8_feed(CRC_INIT, byte_r);
        payload_r <= 40'b0;
        cnt_r     <= CNT_W'(1);
      end else if (!last_byte) begin
        payload_r <= {payload_r[31:0], byte_r};
        crc_r     <= crc8_feed(crc_r, byte_r);
        cnt_r     <= pos + CNT_W'(1);
      end else begin
        cnt_r <= FIRST_POS;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r && last_byte;
    end
    if (advance && last_byte) begin
      o_status_r     <= status_r;
      o_hum_raw_r    <= payload_r[39:20];
      o_temp_raw_r   <= payload_r[19:0];
      o_hum_centi_r  <= hum_centi;
      o_temp_centi_r <= temp_centi;
      o_check_r      <= (crc_r != byte_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, o_temp_centi_r, o_hum_centi_r, o_temp_raw_r, o_hum_raw_r,
                       o_status_r};
  assign out_tuser  = o_check_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_POS)
    else $error("byte count out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && start_r |=> cnt_r == CNT_W'(1))
    else $error("frame start did not restart byte count");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r && last_byte))
    else $error("result without a seventh byte");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last_byte |=> cnt_r == FIRST_POS)
    else $error("byte count did not wrap after seventh byte");

endmodule

// ===== src/htfd_convert.sv =====
// raw sensor words to hundredths of a percent and of a degree
`timescale 1ns / 1ps

module htfd_convert
  import htfd_pkg::*;
(
  input  logic [19:0]        humidity_raw,
  input  logic [19:0]        temperature_raw,
  output logic [13:0]        humidity_centi,
  output logic signed [14:0] temperature_centi
);

  logic [33:0] hum_prod;
  logic [34:0] temp_prod;
  logic [14:0] temp_scaled;

  assign hum_prod    = {14'b0, humidity_raw} * {20'b0, HUM_SCALE};
  assign temp_prod   = {15'b0, temperature_raw} * {20'b0, TEMP_SCALE};
  assign temp_scaled = temp_prod[34:20];

  assign humidity_centi    = hum_prod[33:20];
  assign temperature_centi = signed'(temp_scaled - TEMP_OFFSET);

endmodule
